[src/mcu_pkg.sv]
`timescale 1ns / 1ps

package mcu_pkg;

   // defaults for the top level parameters
   localparam int WINDOW_LENGTH_DEF      = 10;
   localparam int GAIN_FRACTION_BITS_DEF = 12;

   // calibration sample count after reset
   localparam logic [15:0] CAL_SAMPLES_RESET = 16'd5000;

   // shared multiplier operand and product widths
   localparam int MUL_W  = 25;
   localparam int PROD_W = 2 * MUL_W;

   // a min/max range, always non-negative
   localparam int RANGE_W = 17;

   // throttle limits
   localparam logic [10:0] THR_MIN = 11'd1000;
   localparam logic [10:0] THR_MAX = 11'd2000;

   // motor field model: twelve quadratic terms, four per axis
   localparam int TERM_COUNT = 12;
   typedef logic signed [8:0]  coef_type;
   typedef logic signed [29:0] coef_wide_type;

   localparam coef_type MOTOR_A [TERM_COUNT] = '{
      -9'sd30, -9'sd112, 9'sd100, 9'sd120,
      9'sd8, 9'sd105, 9'sd95, 9'sd119,
      9'sd187, -9'sd152, -9'sd87, -9'sd80};
   localparam coef_type MOTOR_B [TERM_COUNT] = '{
      9'sd0, 9'sd0, 9'sd0, 9'sd0,
      9'sd0, -9'sd6, 9'sd36, 9'sd20,
      9'sd0, 9'sd0, 9'sd0, 9'sd0};
   // constant term already scaled by one million
   localparam coef_wide_type MOTOR_C [TERM_COUNT] = '{
      30'sd0, 30'sd0, 30'sd0, 30'sd0,
      30'sd0, 30'sd3000000, 30'sd3000000, 30'sd1000000,
      30'sd0, 30'sd0, 30'sd0, 30'sd0};

   // term / 1e6 done as (|n| >> 6) * ceil(2^36 / 15625) >> 36, exact below 2^28
   localparam int          MOTOR_PRESHIFT = 6;
   localparam int          MOTOR_SHIFT    = 36;
   localparam logic [22:0] RECIP_MOTOR    = 23'd4398047;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SCALE,
      ST_TERM_A,
      ST_TERM_B,
      ST_TERM_N,
      ST_TERM_Q,
      ST_CORR_MUL,
      ST_CORR_SAT,
      ST_WRITE,
      ST_AVG_MUL,
      ST_AVG_SAT,
      ST_CAL,
      ST_GAIN_Y,
      ST_GAIN_Z,
      ST_OUT
   } state_type;

   // gain divider request and response
   typedef struct packed {
      logic               start;
      logic [RANGE_W-1:0] num;
      logic [RANGE_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   // saturate to int16
   function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
      logic signed [15:0] r;
      if (v > 35'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -35'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

[src/mcu_gain_div.sv]
`timescale 1ns / 1ps

module mcu_gain_div #(
   parameter int GAIN_FRACTION_BITS = mcu_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mcu_pkg::div_req_type req,
   output mcu_pkg::div_rsp_type rsp
);
   import mcu_pkg::*;

   localparam int          QBITS    = 16;
   localparam int          ACC_W    = RANGE_W + QBITS + 1;
   localparam logic [15:0] GAIN_ONE = 16'(1 << GAIN_FRACTION_BITS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] dsr_ff, dsr_in;
   logic [15:0]      quo_ff, quo_in;
   logic [3:0]       bit_ff, bit_in;

   logic [ACC_W-1:0] num_ext;
   logic [ACC_W-1:0] den_top;

   // numerator scaled to the gain format, divisor at the saturation point
   assign num_ext = ACC_W'(req.num) << GAIN_FRACTION_BITS;
   assign den_top = ACC_W'(req.den) << QBITS;

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      if (busy_ff) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = quo_ff | (16'd1 << bit_ff);
         end
         dsr_in = dsr_ff >> 1;
         if (bit_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 4'd1;
         end
      end else if (req.start) begin
         if (req.den == '0) begin
            // zero range keeps unity gain
            quo_in  = GAIN_ONE;
            done_in = 1'b1;
         end else if (num_ext >= den_top) begin
            quo_in  = 16'hFFFF;
            done_in = 1'b1;
         end else begin
            quo_in  = '0;
            rem_in  = num_ext;
            dsr_in  = den_top >> 1;
            bit_in  = 4'd15;
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[src/mcu_window_ram.sv]
`timescale 1ns / 1ps

module mcu_window_ram #(
   parameter int WINDOW_LENGTH = mcu_pkg::WINDOW_LENGTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [$clog2(WINDOW_LENGTH)-1:0] rd_addr,
   input  logic                             wr_en,
   input  logic [$clog2(WINDOW_LENGTH)-1:0] wr_addr,
   input  logic [47:0]                      wr_data,
   output logic [47:0]                      rd_data
);
   import mcu_pkg::*;

   logic [47:0]              mem_ff [WINDOW_LENGTH];
   logic [WINDOW_LENGTH-1:0] valid_ff;
   logic [47:0]              rd_data_ff;
   logic                     rd_valid_ff;

   // row valid bits, cleared at reset so the window starts at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // sample storage, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[src/magnetometer_conditioning_unit.sv]
`timescale 1ns / 1ps

// Magnetometer conditioning: offset/gain correction, motor field removal,
// moving average and min/max calibration for one three-axis sample a beat.
//
// Input channel req_*: one raw sample with throttle and a calibration start
// flag per beat. A beat is taken when req_valid is high and req_stall low;
// req_stall stays high from acceptance until the result is in the output
// register. Result channel rsp_*: one result beat per input beat, held in an
// output register until the receiver drops rsp_stall. A finished result
// waits there while the block is idle; a following item runs meanwhile and
// waits only at its end if the previous result is still held.
// All multiplications run through one shared 25x25 multiplier under a sequencer:
// two setup products, three per motor term (twelve terms), one per axis for
// correction and one per axis for the average. On the sample that ends
// calibration the gain divider runs two divisions, one after the other.
// csr_wr_en/csr_wr_data set the calibration sample count; write it only while idle (not enforced by the block).
// Synchronous reset clears offsets, min/max, counters and the window (through
// row valid bits, no clearing pass) and sets both gains to unity.

module magnetometer_conditioning_unit #(
   parameter int WINDOW_LENGTH      = mcu_pkg::WINDOW_LENGTH_DEF,
   parameter int GAIN_FRACTION_BITS = mcu_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_raw_x,
   input  logic signed [15:0] req_raw_y,
   input  logic signed [15:0] req_raw_z,
   input  logic [10:0]        req_throttle,
   input  logic               req_begin_calibration,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_average_x,
   output logic signed [15:0] rsp_average_y,
   output logic signed [15:0] rsp_average_z,
   output logic signed [15:0] rsp_corrected_x,
   output logic signed [15:0] rsp_corrected_y,
   output logic signed [15:0] rsp_corrected_z,
   output logic               rsp_calibrating,
   output logic               rsp_calibration_done,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import mcu_pkg::*;

   localparam int          IDX_W     = $clog2(WINDOW_LENGTH);
   localparam int          SUM_W     = 16 + IDX_W;
   localparam int          AVG_SHIFT = SUM_W + IDX_W;
   localparam logic [63:0] RECIP_W   =
      ((64'd1 << AVG_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [15:0] GAIN_ONE  = 16'(1 << GAIN_FRACTION_BITS);
   localparam logic [33:0] ROUND_ADJ = 34'((1 << GAIN_FRACTION_BITS) - 1);

   state_type state_ff, state_in;

   logic signed [15:0]      raw_ff [3];
   logic signed [15:0]      raw_in [3];
   logic [9:0]              t_ff, t_in;
   logic [19:0]             tt_ff, tt_in;
   logic [19:0]             t1k_ff, t1k_in;
   logic signed [29:0]      nacc_ff, nacc_in;
   logic [3:0]              term_ff, term_in;
   logic [1:0]              axis_ff, axis_in;
   logic                    neg_ff, neg_in;
   logic signed [10:0]      moto_ff [3];
   logic signed [10:0]      moto_in [3];
   logic signed [15:0]      corr_ff [3];
   logic signed [15:0]      corr_in [3];
   logic signed [15:0]      avg_ff [3];
   logic signed [15:0]      avg_in [3];
   logic signed [15:0]      off_ff [3];
   logic signed [15:0]      off_in [3];
   logic [15:0]             gain_ff [2];
   logic [15:0]             gain_in [2];
   logic signed [15:0]      min_ff [3];
   logic signed [15:0]      min_in [3];
   logic signed [15:0]      max_ff [3];
   logic signed [15:0]      max_in [3];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];
   logic [RANGE_W-1:0]      rx_ff, rx_in;
   logic [RANGE_W-1:0]      rz_ff, rz_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [15:0]             count_ff, count_in;
   logic                    cal_ff, cal_in;
   logic                    done_ff, done_in;
   logic [15:0]             csr_ff;

   logic signed [15:0] out_avg_ff [3];
   logic signed [15:0] out_avg_in [3];
   logic signed [15:0] out_corr_ff [3];
   logic signed [15:0] out_corr_in [3];
   logic               out_cal_ff, out_cal_in;
   logic               out_done_ff, out_done_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   logic        win_rd_en, win_wr_en;
   logic [47:0] win_wr_data, win_rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer and datapath next state
   always_comb begin
      logic [10:0]             thr;
      logic                    cal_now;
      logic signed [29:0]      n_val;
      logic [29:0]             n_mag;
      logic [8:0]              q_mot;
      logic signed [15:0]      d_val;
      logic [15:0]             g_val;
      logic signed [33:0]      p_val;
      logic signed [33:0]      p_adj;
      logic signed [33:0]      p_sh;
      logic signed [15:0]      w_val [3];
      logic signed [15:0]      old_val;
      logic [SUM_W-1:0]        s_mag;
      logic [16:0]             q_avg;
      logic signed [RANGE_W-1:0] mid;
      logic [RANGE_W-1:0]      rng [3];
      logic [15:0]             cnt_next;

      state_in     = state_ff;
      raw_in       = raw_ff;
      t_in         = t_ff;
      tt_in        = tt_ff;
      t1k_in       = t1k_ff;
      nacc_in      = nacc_ff;
      term_in      = term_ff;
      axis_in      = axis_ff;
      neg_in       = neg_ff;
      moto_in      = moto_ff;
      corr_in      = corr_ff;
      avg_in       = avg_ff;
      off_in       = off_ff;
      gain_in      = gain_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      rx_in        = rx_ff;
      rz_in        = rz_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      cal_in       = cal_ff;
      done_in      = done_ff;
      out_avg_in   = out_avg_ff;
      out_corr_in  = out_corr_ff;
      out_cal_in   = out_cal_ff;
      out_done_in  = out_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mul_a       = '0;
      mul_b       = '0;
      win_rd_en   = 1'b0;
      win_wr_en   = 1'b0;
      win_wr_data = '0;
      div_req     = '0;

      thr      = '0;
      cal_now  = 1'b0;
      n_val    = '0;
      n_mag    = '0;
      q_mot    = '0;
      d_val    = '0;
      g_val    = '0;
      p_val    = '0;
      p_adj    = '0;
      p_sh     = '0;
      w_val    = '{default: '0};
      old_val  = '0;
      s_mag    = '0;
      q_avg    = '0;
      mid      = '0;
      rng      = '{default: '0};
      cnt_next = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               raw_in[0] = req_raw_x;
               raw_in[1] = req_raw_y;
               raw_in[2] = req_raw_z;
               // clamp throttle to its band
               thr = req_throttle;
               if (thr < THR_MIN) begin
                  thr = THR_MIN;
               end else if (thr > THR_MAX) begin
                  thr = THR_MAX;
               end
               t_in = 10'(thr - THR_MIN);
               // calibration forces unity correction
               cal_now = cal_ff || req_begin_calibration;
               cal_in  = cal_now;
               if (cal_now) begin
                  off_in  = '{default: '0};
                  gain_in = '{default: GAIN_ONE};
               end
               moto_in  = '{default: '0};
               done_in  = 1'b0;
               term_in  = '0;
               axis_in  = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            mul_a    = MUL_W'(t_ff);
            mul_b    = MUL_W'(t_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mul_a    = MUL_W'(t_ff);
            mul_b    = MUL_W'(11'd1000);
            tt_in    = prod_ff[19:0];
            state_in = ST_TERM_A;
         end
         ST_TERM_A: begin
            if (term_ff == 4'd0) begin
               t1k_in = prod_ff[19:0];
            end
            mul_a    = MUL_W'(MOTOR_A[term_ff]);
            mul_b    = MUL_W'(tt_ff);
            state_in = ST_TERM_B;
         end
         ST_TERM_B: begin
            nacc_in  = signed'(prod_ff[29:0]);
            mul_a    = MUL_W'(MOTOR_B[term_ff]);
            mul_b    = MUL_W'(t1k_ff);
            state_in = ST_TERM_N;
         end
         ST_TERM_N: begin
            // full term numerator, then truncating divide by one million
            n_val    = nacc_ff + signed'(prod_ff[29:0]) + MOTOR_C[term_ff];
            n_mag    = n_val[29] ? 30'(-n_val) : 30'(n_val);
            neg_in   = n_val[29];
            mul_a    = MUL_W'(n_mag[27:MOTOR_PRESHIFT]);
            mul_b    = MUL_W'(RECIP_MOTOR);
            state_in = ST_TERM_Q;
         end
         ST_TERM_Q: begin
            q_mot = prod_ff[MOTOR_SHIFT +: 9];
            if (neg_ff) begin
               moto_in[term_ff[3:2]] = moto_ff[term_ff[3:2]] - 11'(q_mot);
            end else begin
               moto_in[term_ff[3:2]] = moto_ff[term_ff[3:2]] + 11'(q_mot);
            end
            if (term_ff == 4'(TERM_COUNT - 1)) begin
               axis_in  = '0;
               state_in = ST_CORR_MUL;
            end else begin
               term_in  = term_ff + 4'd1;
               state_in = ST_TERM_A;
            end
         end
         ST_CORR_MUL: begin
            d_val    = raw_ff[axis_ff] - off_ff[axis_ff];
            g_val    = (axis_ff == 2'd0) ? GAIN_ONE : gain_ff[axis_ff[1]];
            mul_a    = MUL_W'(g_val);
            mul_b    = MUL_W'(d_val);
            // fetch the oldest window row early
            win_rd_en = (axis_ff == 2'd0);
            state_in = ST_CORR_SAT;
         end
         ST_CORR_SAT: begin
            // gain product, truncated toward zero
            p_val = signed'(prod_ff[33:0]);
            p_adj = p_val[33] ? p_val + signed'(ROUND_ADJ) : p_val;
            p_sh  = p_adj >>> GAIN_FRACTION_BITS;
            corr_in[axis_ff] = sat16(35'(p_sh));
            if (axis_ff == 2'd2) begin
               axis_in  = '0;
               state_in = ST_WRITE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_CORR_MUL;
            end
         end
         ST_WRITE: begin
            // motor removal, window write and running sums
            for (int j = 0; j < 3; j++) begin
               w_val[j]  = sat16(35'(corr_ff[j]) - 35'(moto_ff[j]));
               old_val   = signed'(win_rd_data[16*j +: 16]);
               sum_in[j] = sum_ff[j] + SUM_W'(w_val[j]) - SUM_W'(old_val);
            end
            win_wr_en   = 1'b1;
            win_wr_data = {w_val[2], w_val[1], w_val[0]};
            idx_in      = (idx_ff == IDX_W'(WINDOW_LENGTH - 1)) ? '0 : idx_ff + 1'b1;
            axis_in     = '0;
            state_in    = ST_AVG_MUL;
         end
         ST_AVG_MUL: begin
            s_mag    = sum_ff[axis_ff][SUM_W-1] ? SUM_W'(-sum_ff[axis_ff])
                                                : SUM_W'(sum_ff[axis_ff]);
            neg_in   = sum_ff[axis_ff][SUM_W-1];
            mul_a    = MUL_W'(s_mag);
            mul_b    = MUL_W'(RECIP_W);
            state_in = ST_AVG_SAT;
         end
         ST_AVG_SAT: begin
            q_avg = prod_ff[AVG_SHIFT +: 17];
            avg_in[axis_ff] = neg_ff ? 16'(-q_avg) : 16'(q_avg);
            if (axis_ff == 2'd2) begin
               state_in = ST_CAL;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_AVG_MUL;
            end
         end
         ST_CAL: begin
            state_in = ST_OUT;
            if (cal_ff) begin
               for (int j = 0; j < 3; j++) begin
                  if (corr_ff[j] < min_ff[j]) begin
                     min_in[j] = corr_ff[j];
                  end
                  if (corr_ff[j] > max_ff[j]) begin
                     max_in[j] = corr_ff[j];
                  end
               end
               cnt_next = count_ff + 16'd1;
               count_in = cnt_next;
               if (cnt_next == csr_ff) begin
                  // midpoints and ranges from the updated extremes
                  for (int j = 0; j < 3; j++) begin
                     mid       = RANGE_W'(min_in[j]) + RANGE_W'(max_in[j]);
                     mid       = mid + (mid[RANGE_W-1] ? 17'sd1 : 17'sd0);
                     off_in[j] = 16'(mid >>> 1);
                     rng[j]    = RANGE_W'(max_in[j]) - RANGE_W'(min_in[j]);
                  end
                  rx_in         = rng[0];
                  rz_in         = rng[2];
                  div_req.start = 1'b1;
                  div_req.num   = rng[0];
                  div_req.den   = rng[1];
                  cal_in        = 1'b0;
                  count_in      = '0;
                  done_in       = 1'b1;
                  state_in      = ST_GAIN_Y;
               end
            end
         end
         ST_GAIN_Y: begin
            if (div_rsp.done) begin
               gain_in[0]    = div_rsp.quotient;
               div_req.start = 1'b1;
               div_req.num   = rx_ff;
               div_req.den   = rz_ff;
               state_in      = ST_GAIN_Z;
            end
         end
         ST_GAIN_Z: begin
            if (div_rsp.done) begin
               gain_in[1] = div_rsp.quotient;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               out_avg_in   = avg_ff;
               out_corr_in  = corr_ff;
               out_cal_in   = cal_ff;
               out_done_in  = done_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '{default: '0};
         gain_ff      <= '{default: GAIN_ONE};
         min_ff       <= '{default: '0};
         max_ff       <= '{default: '0};
         sum_ff       <= '{default: '0};
         idx_ff       <= '0;
         count_ff     <= '0;
         cal_ff       <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= CAL_SAMPLES_RESET;
      end else begin
         off_ff       <= off_in;
         gain_ff      <= gain_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         cal_ff       <= cal_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   // working registers and product
   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      raw_ff      <= raw_in;
      t_ff        <= t_in;
      tt_ff       <= tt_in;
      t1k_ff      <= t1k_in;
      nacc_ff     <= nacc_in;
      term_ff     <= term_in;
      axis_ff     <= axis_in;
      neg_ff      <= neg_in;
      moto_ff     <= moto_in;
      corr_ff     <= corr_in;
      avg_ff      <= avg_in;
      rx_ff       <= rx_in;
      rz_ff       <= rz_in;
      out_avg_ff  <= out_avg_in;
      out_corr_ff <= out_corr_in;
      out_cal_ff  <= out_cal_in;
      out_done_ff <= out_done_in;
   end

   mcu_window_ram #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (win_rd_en),
      .rd_addr (idx_ff),
      .wr_en   (win_wr_en),
      .wr_addr (idx_ff),
      .wr_data (win_wr_data),
      .rd_data (win_rd_data)
   );

   mcu_gain_div #(
      .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
   ) u_gain_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_average_x        = out_avg_ff[0];
   assign rsp_average_y        = out_avg_ff[1];
   assign rsp_average_z        = out_avg_ff[2];
   assign rsp_corrected_x      = out_corr_ff[0];
   assign rsp_corrected_y      = out_corr_ff[1];
   assign rsp_corrected_z      = out_corr_ff[2];
   assign rsp_calibrating      = out_cal_ff;
   assign rsp_calibration_done = out_done_ff;

   // finishing calibration always leaves calibration mode
   a_done_not_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_calibrating && rsp_calibration_done))
      else $error("calibration done while still calibrating");

   // window pointer stays inside the window
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(WINDOW_LENGTH - 1))
      else $error("window index out of range");

   // an accepted beat starts the sequence
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SQUARE))
      else $error("accepted beat did not start the sequence");

   // divider results arrive only while gains are being computed
   a_div_window: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_GAIN_Y || state_ff == ST_GAIN_Z))
      else $error("unexpected divider result");

endmodule
